// File: sv/assert_macros.svh
// Assertion helpers shared by the lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FDEL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define FDEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/fdel_pkg.sv
// ----------------------------------------------------------------------------
// fdel_pkg
// Types, codes and constants of the FAT32 directory entry lookup.
// ----------------------------------------------------------------------------
package fdel_pkg;

    localparam int LFN_CHARS = 13;
    localparam int S_DATA_W  = 304;
    localparam int M_DATA_W  = 136;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;

    // input kinds
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_ENTRY = 2'd2;

    // result status
    localparam logic [1:0] ST_SCAN  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_BASE     = 2'd0;
    localparam logic [1:0] REG_EXT      = 2'd1;
    localparam logic [1:0] REG_NAME_LEN = 2'd2;

    localparam logic [63:0] BASE_RESET = 64'h2020202020202020;
    localparam logic [23:0] EXT_RESET  = 24'h202020;

    localparam logic [7:0]  ATTR_LFN      = 8'h0F;
    localparam logic [7:0]  SEQ_LAST_MASK = 8'h40;
    localparam logic [5:0]  SEQ_NUM_MASK  = 6'h3F;
    localparam logic [7:0]  DIR_END       = 8'h00;
    localparam logic [7:0]  DIR_DELETED   = 8'hE5;
    localparam logic [7:0]  CASE_GAP      = 8'h20;
    localparam logic [15:0] UNIT_NONE     = 16'h0000;
    localparam logic [15:0] UNIT_PAD      = 16'hFFFF;

    // byte offsets of the 13 name code units inside a long-name entry
    localparam logic [4:0] LFN_OFFSET [LFN_CHARS] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9,
        5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
        5'd28, 5'd30
    };

    typedef struct packed {
        logic [63:0] base;
        logic [23:0] ext;
        logic [7:0]  name_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_index;
        logic [7:0]  char_value;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [31:0] sector;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_sector;
        logic [7:0]  entry_attr;
        logic [31:0] start_cluster;
        logic [31:0] file_size;
        logic [15:0] mod_time;
        logic [15:0] mod_date;
    } result_t;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

endpackage

// File: sv/fat_dir_entry_lookup.sv
// ----------------------------------------------------------------------------
// fat_dir_entry_lookup
// FAT32 directory name lookup with long-name support over a stream of entries.
// ----------------------------------------------------------------------------
// An entry is taken into the input register, then its result into the result
// register that drives m_tvalid. Throughput: one item per cycle while a held
// result is not stalled by m_tready; the 13 lane compares and the group match
// reduction sit between the input register and the result register.
// Reset clears the long-name sequence and length state and the valid bits;
// the target name memory, the match bits and data registers are not cleared.
`include "assert_macros.svh"

module fat_dir_entry_lookup #(
    parameter int MAX_LFN_CHARS  = 260,
    parameter int MAX_NAME_CHARS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // char_index, char_value, entry_word0, entry_word1, entry_word2,
    // entry_word3, sector_tag
    input  logic [fdel_pkg::S_DATA_W-1:0]  s_tdata,
    // op
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_sector, entry_attr, start_cluster, file_size, mod_time, mod_date
    output logic [fdel_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                     m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdel_pkg::APB_AW-1:0]    paddr,
    input  logic [fdel_pkg::APB_DW-1:0]    pwdata,
    output logic [fdel_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import fdel_pkg::*;

    localparam int NR  = (MAX_NAME_CHARS + LFN_CHARS - 1) / LFN_CHARS;
    localparam int RAW = $clog2(NR);

    cfg_t                   cfg;
    item_t                  s_item;
    item_t                  p1_item_reg;
    logic                   p1_valid_reg;
    logic                   p1_adv;
    logic                   s_accept;
    logic                   has_res;
    result_t                res;
    result_t                m_res_reg;
    logic                   m_valid_reg;
    logic [RAW-1:0]         rd_addr;
    logic [LFN_CHARS*8-1:0] rd_row;

    assign pready = 1'b1;

    assign s_item.op         = s_tuser;
    assign s_item.char_index = s_tdata[7:0];
    assign s_item.char_value = s_tdata[15:8];
    assign s_item.w0         = s_tdata[79:16];
    assign s_item.w1         = s_tdata[143:80];
    assign s_item.w2         = s_tdata[207:144];
    assign s_item.w3         = s_tdata[271:208];
    assign s_item.sector     = s_tdata[303:272];

    // advance stage 1 when it has no result or the result register frees up
    assign p1_adv   = p1_valid_reg && (!has_res || !m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv && has_res) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && has_res) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {m_res_reg.mod_date, m_res_reg.mod_time, m_res_reg.file_size,
                       m_res_reg.start_cluster, m_res_reg.entry_attr,
                       m_res_reg.found_sector};

    fdel_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fdel_name_store #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_name (
        .clk      (aclk),
        .wr_en    (s_accept && s_tuser == OP_LOAD),
        .wr_index (s_item.char_index),
        .wr_data  (s_item.char_value),
        .rd_en    (s_accept),
        .rd_addr  (rd_addr),
        .rd_row   (rd_row)
    );

    fdel_scan_core #(
        .MAX_LFN_CHARS  (MAX_LFN_CHARS),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_core (
        .clk      (aclk),
        .rstn     (aresetn),
        .p1_valid (p1_valid_reg),
        .p1_item  (p1_item_reg),
        .p1_adv   (p1_adv),
        .cfg      (cfg),
        .rd_row   (rd_row),
        .nxt_b0   (s_item.w0[7:0]),
        .nxt_b11  (s_item.w1[31:24]),
        .rd_addr  (rd_addr),
        .has_res  (has_res),
        .res      (res)
    );

    `FDEL_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> (p1_valid_reg && m_valid_reg && !m_tready), "input stalled without a blocked result")

endmodule

// File: sv/fdel_cfg_regs.sv
// ----------------------------------------------------------------------------
// fdel_cfg_regs
// APB register file: target 8.3 name and target long-name length.
// ----------------------------------------------------------------------------
module fdel_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdel_pkg::APB_AW-1:0]  paddr,
    input  logic [fdel_pkg::APB_DW-1:0]  pwdata,
    output logic [fdel_pkg::APB_DW-1:0]  prdata,
    output fdel_pkg::cfg_t               cfg
);
    import fdel_pkg::*;

    logic [1:0]  reg_idx;
    logic        wr_en;
    logic [63:0] base_reg;
    logic [23:0] ext_reg;
    logic [7:0]  name_len_reg;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= BASE_RESET;
            ext_reg      <= EXT_RESET;
            name_len_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BASE:     base_reg     <= pwdata;
                REG_EXT:      ext_reg      <= pwdata[23:0];
                REG_NAME_LEN: name_len_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BASE:     prdata = base_reg;
            REG_EXT:      prdata = {40'd0, ext_reg};
            REG_NAME_LEN: prdata = {56'd0, name_len_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.base        = base_reg;
    assign cfg.ext         = ext_reg;
    assign cfg.name_length = name_len_reg;

endmodule

// File: sv/fdel_name_store.sv
// ----------------------------------------------------------------------------
// fdel_name_store
// Target long-name memory, one row per 13 characters, byte-lane writes.
// ----------------------------------------------------------------------------
module fdel_name_store #(
    parameter int MAX_NAME_CHARS = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [7:0]                            wr_index,
    input  logic [7:0]                            wr_data,
    input  logic                                  rd_en,
    input  logic [$clog2((MAX_NAME_CHARS + fdel_pkg::LFN_CHARS - 1) /
                         fdel_pkg::LFN_CHARS)-1:0] rd_addr,
    output logic [fdel_pkg::LFN_CHARS*8-1:0]      rd_row
);
    import fdel_pkg::*;

    localparam int NR = (MAX_NAME_CHARS + LFN_CHARS - 1) / LFN_CHARS;
    localparam int RAW = $clog2(NR);
    // floor(index / 13) for an 8-bit index, low by at most one
    localparam logic [16:0] RECIP_MUL = 17'd315;
    localparam int RECIP_SHIFT = 12;

    logic [LFN_CHARS*8-1:0] mem [NR];
    logic [16:0] prod;
    logic [4:0]  q0;
    logic [7:0]  r0;
    logic        corr;
    logic [4:0]  row;
    logic [3:0]  lane;
    logic        in_range;

    assign prod     = 17'(wr_index) * RECIP_MUL;
    assign q0       = prod[RECIP_SHIFT +: 5];
    assign r0       = wr_index - 8'(LFN_CHARS * int'(q0));
    assign corr     = int'(r0) >= LFN_CHARS;
    assign row      = q0 + {4'd0, corr};
    assign lane     = corr ? 4'(int'(r0) - LFN_CHARS) : r0[3:0];
    assign in_range = int'(wr_index) < MAX_NAME_CHARS;

    always_ff @(posedge clk) begin
        if (wr_en && in_range) begin
            mem[RAW'(row)][8*lane +: 8] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_row <= mem[rd_addr];
        end
    end

endmodule

// File: sv/fdel_scan_core.sv
// ----------------------------------------------------------------------------
// fdel_scan_core
// Per-entry decode, long-name sequence tracking, character match bits and
// the short-entry match decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdel_scan_core #(
    parameter int MAX_LFN_CHARS  = 260,
    parameter int MAX_NAME_CHARS = 256
) (
    input  logic                              clk,
    input  logic                              rstn,
    input  logic                              p1_valid,
    input  fdel_pkg::item_t                   p1_item,
    input  logic                              p1_adv,
    input  fdel_pkg::cfg_t                    cfg,
    input  logic [fdel_pkg::LFN_CHARS*8-1:0]  rd_row,
    input  logic [7:0]                        nxt_b0,
    input  logic [7:0]                        nxt_b11,
    output logic [$clog2((MAX_NAME_CHARS + fdel_pkg::LFN_CHARS - 1) /
                         fdel_pkg::LFN_CHARS)-1:0] rd_addr,
    output logic                              has_res,
    output fdel_pkg::result_t                 res
);
    import fdel_pkg::*;

    localparam int NG  = MAX_LFN_CHARS / LFN_CHARS;
    localparam int NR  = (MAX_NAME_CHARS + LFN_CHARS - 1) / LFN_CHARS;
    localparam int RAW = $clog2(NR);
    localparam int GW  = $clog2(NG + 1);
    localparam int PW  = $clog2(LFN_CHARS * NG + 1);

    // long-name state: length kept as (group, offset) with length = 13*group + offset
    logic [5:0]           es_reg;
    logic [GW-1:0]        grp_reg;
    logic [3:0]           off_reg;
    logic [LFN_CHARS-1:0] pm_reg  [NG];
    logic [NG-1:0]        gok_reg;

    logic [5:0]           es_next;
    logic [GW-1:0]        grp_next;
    logic [3:0]           off_next;
    logic                 pm_wr;

    logic [255:0]         ent;
    logic [7:0]           b0;
    logic [7:0]           b11;
    logic                 is_end;
    logic                 is_del;
    logic                 is_lfn;
    logic                 seq_last;
    logic [5:0]           es_l;
    logic                 lfn_ok;
    logic [5:0]           g;
    logic [PW-1:0]        pbase;
    logic [LFN_CHARS-1:0] term;
    logic [LFN_CHARS-1:0] alive;
    logic [LFN_CHARS-1:0] nm;
    logic [3:0]           n_chars;
    logic [GW-1:0]        e_grp;
    logic [3:0]           e_off;
    logic [GW-1:0]        b_grp;
    logic [3:0]           b_off;
    logic                 longer;
    logic [LFN_CHARS-1:0] offmask;
    logic [NG-1:0]        part_ok;
    logic [NG-1:0]        upd_and;
    logic                 long_ok;
    logic [PW-1:0]        plen;
    logic [7:0]           tq;
    logic                 found_long;
    logic                 sn_match;
    logic                 s_lfn;
    logic [5:0]           s_es;
    logic [6:0]           row_w;

    assign ent      = {p1_item.w3, p1_item.w2, p1_item.w1, p1_item.w0};
    assign b0       = ent[7:0];
    assign b11      = ent[95:88];
    assign is_end   = b0 == DIR_END;
    assign is_del   = b0 == DIR_DELETED;
    assign is_lfn   = b11 == ATTR_LFN;
    assign seq_last = (b0 & SEQ_LAST_MASK) != 8'd0;
    assign es_l     = seq_last ? (b0[5:0] & SEQ_NUM_MASK) : es_reg;
    assign lfn_ok   = es_l != 6'd0 && (b0[5:0] & SEQ_NUM_MASK) == es_l && int'(es_l) <= NG;
    assign g        = es_l - 6'd1;
    assign pbase    = PW'(LFN_CHARS * int'(g));

    // lane decode: terminator search and per-character compare
    always_comb begin
        logic [15:0]   unit;
        logic [7:0]    t;
        logic [PW-1:0] p;
        for (int k = 0; k < LFN_CHARS; k++) begin
            unit    = ent[8*LFN_OFFSET[k] +: 16];
            term[k] = unit == UNIT_NONE || unit == UNIT_PAD;
        end
        // keep lanes below the first terminator
        alive = (term == '0) ? '1 : ((term & (~term + 13'd1)) - 13'd1);
        n_chars = 4'd0;
        for (int k = 0; k < LFN_CHARS; k++) begin
            unit = ent[8*LFN_OFFSET[k] +: 16];
            p    = pbase + PW'(k);
            t    = (int'(p) < int'(cfg.name_length) && int'(p) < MAX_NAME_CHARS)
                   ? rd_row[8*k +: 8] : 8'd0;
            nm[k] = t != 8'd0 && fold_upper(unit[7:0]) == fold_upper(t);
            if (alive[k]) begin
                n_chars = 4'(k + 1);
            end
        end
    end

    assign e_grp  = alive[LFN_CHARS-1] ? GW'(g) + GW'(1) : GW'(g);
    assign e_off  = alive[LFN_CHARS-1] ? 4'd0 : n_chars;
    assign b_grp  = seq_last ? '0 : grp_reg;
    assign b_off  = seq_last ? 4'd0 : off_reg;
    assign longer = (e_grp > b_grp) || (e_grp == b_grp && e_off > b_off);

    // match bits per group: partial prefix for the group holding the length end,
    // and the refreshed full-group AND for the group being written
    assign offmask = (13'd1 << off_reg) - 13'd1;
    always_comb begin
        for (int r = 0; r < NG; r++) begin
            part_ok[r] = &(pm_reg[r] | ~offmask);
            upd_and[r] = &((alive & nm) | (~alive & pm_reg[r]));
        end
        long_ok = 1'b1;
        for (int r = 0; r < NG; r++) begin
            if (int'(grp_reg) > r) begin
                long_ok = long_ok & gok_reg[r];
            end else if (int'(grp_reg) == r) begin
                long_ok = long_ok & part_ok[r];
            end
        end
    end

    assign plen = PW'(LFN_CHARS * int'(grp_reg)) + PW'(off_reg);
    always_comb begin
        logic [7:0] lane_byte;
        lane_byte = 8'd0;
        for (int k = 0; k < LFN_CHARS; k++) begin
            if (int'(off_reg) == k) begin
                lane_byte = rd_row[8*k +: 8];
            end
        end
        tq = (int'(plen) < int'(cfg.name_length) && int'(plen) < MAX_NAME_CHARS)
             ? lane_byte : 8'd0;
    end

    assign found_long = (grp_reg != '0 || off_reg != 4'd0) && long_ok && tq == 8'd0;
    assign sn_match   = p1_item.w0 == cfg.base && p1_item.w1[23:0] == cfg.ext;

    // next state
    always_comb begin
        es_next  = es_reg;
        grp_next = grp_reg;
        off_next = off_reg;
        pm_wr    = 1'b0;
        if (p1_valid) begin
            unique case (p1_item.op)
                OP_START: begin
                    es_next  = 6'd0;
                    grp_next = '0;
                    off_next = 4'd0;
                end
                OP_ENTRY: begin
                    priority if (is_end) begin
                        es_next = es_reg;
                    end else if (is_del) begin
                        grp_next = '0;
                        off_next = 4'd0;
                    end else if (is_lfn) begin
                        if (lfn_ok) begin
                            es_next  = es_l - 6'd1;
                            grp_next = longer ? e_grp : b_grp;
                            off_next = longer ? e_off : b_off;
                            pm_wr    = alive[0];
                        end else begin
                            es_next  = 6'd0;
                            grp_next = '0;
                            off_next = 4'd0;
                        end
                    end else begin
                        grp_next = '0;
                        off_next = 4'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            es_reg  <= 6'd0;
            grp_reg <= '0;
            off_reg <= 4'd0;
        end else if (p1_adv) begin
            es_reg  <= es_next;
            grp_reg <= grp_next;
            off_reg <= off_next;
        end
    end

    always_ff @(posedge clk) begin
        for (int r = 0; r < NG; r++) begin
            if (p1_adv && pm_wr && int'(g) == r) begin
                for (int k = 0; k < LFN_CHARS; k++) begin
                    if (alive[k]) begin
                        pm_reg[r][k] <= nm[k];
                    end
                end
                gok_reg[r] <= upd_and[r];
            end
        end
    end

    // result
    assign has_res = p1_valid && p1_item.op == OP_ENTRY;
    always_comb begin
        res = '0;
        if (is_end) begin
            res.status = ST_END;
        end else if (!is_del && !is_lfn && (found_long || sn_match)) begin
            res.status        = ST_FOUND;
            res.found_sector  = p1_item.sector;
            res.entry_attr    = b11;
            res.start_cluster = {p1_item.w2[47:32], p1_item.w3[31:16]};
            res.file_size     = p1_item.w3[63:32];
            res.mod_time      = p1_item.w2[63:48];
            res.mod_date      = p1_item.w3[15:0];
        end
    end

    // name row for the incoming item, seen against the state this item leaves
    assign s_lfn = nxt_b11 == ATTR_LFN;
    assign s_es  = ((nxt_b0 & SEQ_LAST_MASK) != 8'd0) ? (nxt_b0[5:0] & SEQ_NUM_MASK) : es_next;
    assign row_w = s_lfn ? ({1'b0, s_es} - 7'd1) : 7'(grp_next);
    assign rd_addr = (int'(row_w) < NR) ? RAW'(row_w) : '0;

    `FDEL_ASSERT(a_seq_bound, clk, rstn, int'(es_reg) < NG || es_reg == 6'd0, "sequence count beyond long-name capacity")
    `FDEL_ASSERT(a_len_bound, clk, rstn, (int'(grp_reg) < NG && int'(off_reg) < LFN_CHARS) || (int'(grp_reg) == NG && off_reg == 4'd0), "long-name length out of range")
    `FDEL_ASSERT_ALWAYS(a_reset_clear, clk, !rstn |=> (es_reg == 6'd0 && grp_reg == '0 && off_reg == 4'd0), "long-name state not cleared by reset")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the FAT32 directory lookup: a driver and a monitor
// with random stalls on both sides, APB register writes between phases, and
// a predictor of every status and matched-entry field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdel_pkg::*;

    localparam int MAX_LFN      = 260;
    localparam int MAX_NAME     = 256;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 80;
    localparam int SETTLE       = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 27;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // ways of breaking a long-name run
    localparam int BRK_NONE   = 0;
    localparam int BRK_SKIP   = 1;
    localparam int BRK_NOLAST = 2;
    localparam int BRK_INSERT = 3;
    localparam int BRK_BADSEQ = 4;

    // short-entry name choice
    localparam int SN_MATCH  = 0;
    localparam int SN_NEAR   = 1;
    localparam int SN_RANDOM = 2;

    typedef struct packed {
        logic  drain_first;
        item_t item;
    } pend_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    fat_dir_entry_lookup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic [8:0]  lfn_len;
    logic [5:0]  seq_next;
    bit          char_hit [0:MAX_LFN-1];
    logic [7:0]  target_name [0:MAX_NAME-1];
    logic [63:0] tgt_base;
    logic [23:0] tgt_ext;
    logic [7:0]  tgt_len;

    // stimulus state
    pend_t       pending [$];
    result_t     expected_results [$];
    item_t       cur_item;
    bit          offering;
    bit          steady;
    bit          drain_next;
    int          phase_items;
    int          errors;
    int          cycles;
    logic [7:0]  want_name [0:MAX_NAME-1];
    int          want_len;
    logic [7:0]  lname [0:MAX_LFN+3];
    int          lname_len;
    logic [63:0] phase_base;
    logic [23:0] phase_ext;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // byte offset of name code unit k inside a long-name entry
    function automatic int unit_byte(input int k);
        if (k < 5) return 1 + 2 * k;
        if (k < 11) return 14 + 2 * (k - 5);
        return 28 + 2 * (k - 11);
    endfunction

    function automatic logic [7:0] target_char(input int i);
        if (i < int'(tgt_len) && i < MAX_NAME) return target_name[i];
        return 8'h00;
    endfunction

    task automatic predict_lookup(input item_t it);
        logic [255:0] ent;
        logic [7:0]   seq_b;
        logic [7:0]   t;
        logic [15:0]  unit;
        result_t      r;
        int           base_pos;
        int           p;
        int           k;
        bit           hit;
        bit           stop;
        ent = {it.w3, it.w2, it.w1, it.w0};
        r = '0;
        if (it.op == OP_START) begin
            lfn_len = '0;
            seq_next = '0;
        end else if (it.op == OP_LOAD) begin
            target_name[it.char_index] = it.char_value;
        end else if (it.op == OP_ENTRY) begin
            if (ent[7:0] == DIR_END) begin
                r.status = ST_END;
            end else if (ent[7:0] == DIR_DELETED) begin
                lfn_len = '0;
            end else if (ent[95:88] == ATTR_LFN) begin
                seq_b = ent[7:0];
                if ((seq_b & SEQ_LAST_MASK) != 8'h00) begin
                    lfn_len = '0;
                    seq_next = seq_b[5:0];
                end
                if (seq_next != 6'd0 && seq_b[5:0] == seq_next &&
                    int'(seq_next) * LFN_CHARS <= MAX_LFN) begin
                    base_pos = (int'(seq_next) - 1) * LFN_CHARS;
                    stop = 1'b0;
                    for (k = 0; k < LFN_CHARS; k++) begin
                        unit = ent[8*unit_byte(k) +: 16];
                        p = base_pos + k;
                        if (stop || unit == UNIT_NONE || unit == UNIT_PAD || p >= MAX_LFN) begin
                            stop = 1'b1;
                        end else begin
                            t = target_char(p);
                            char_hit[p] = (t != 8'h00) && (upcase(unit[7:0]) == upcase(t));
                            if (p + 1 > int'(lfn_len)) lfn_len = 9'(p + 1);
                        end
                    end
                    seq_next = seq_next - 6'd1;
                end else begin
                    lfn_len = '0;
                    seq_next = '0;
                end
            end else begin
                hit = (lfn_len != 9'd0);
                for (k = 0; k < int'(lfn_len); k++) begin
                    if (!char_hit[k]) hit = 1'b0;
                end
                if (hit && target_char(int'(lfn_len)) != 8'h00) hit = 1'b0;
                lfn_len = '0;
                if (!hit) hit = (ent[63:0] == tgt_base) && (ent[87:64] == tgt_ext);
                if (hit) begin
                    r.status        = ST_FOUND;
                    r.found_sector  = it.sector;
                    r.entry_attr    = ent[95:88];
                    r.start_cluster = {ent[175:160], ent[223:208]};
                    r.file_size     = ent[255:224];
                    r.mod_time      = ent[191:176];
                    r.mod_date      = ent[207:192];
                end
            end
            expected_results.push_back(r);
        end
    endtask

    // driver: present the next pending transaction once the current one is taken
    always @(posedge aclk) begin : drive
        bit    fire;
        bit    go;
        pend_t nx;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire) predict_lookup(cur_item);
            if (fire || !s_tvalid) begin
                go = (pending.size() > 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
                if (go && pending[0].drain_first && expected_results.size() != 0) go = 1'b0;
                if (go) begin
                    nx = pending.pop_front();
                    cur_item = nx.item;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nx.item.sector, nx.item.w3, nx.item.w2, nx.item.w1,
                                 nx.item.w0, nx.item.char_value, nx.item.char_index};
                    s_tuser  <= nx.item.op;
                    offering = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                    offering = 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status        = m_tuser;
                got.found_sector  = m_tdata[31:0];
                got.entry_attr    = m_tdata[39:32];
                got.start_cluster = m_tdata[71:40];
                got.file_size     = m_tdata[103:72];
                got.mod_time      = m_tdata[119:104];
                got.mod_date      = m_tdata[135:120];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0h",
                             $time, m_tuser);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("found_sector", want.found_sector, got.found_sector);
                    check_field("entry_attr", want.entry_attr, got.entry_attr);
                    check_field("start_cluster", want.start_cluster, got.start_cluster);
                    check_field("file_size", want.file_size, got.file_size);
                    check_field("mod_time", want.mod_time, got.mod_time);
                    check_field("mod_date", want.mod_date, got.mod_date);
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("fat_dir_entry_lookup verification failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE:     tgt_base = value;
            REG_EXT:      tgt_ext  = value[23:0];
            REG_NAME_LEN: tgt_len  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || offering || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [255:0] rand_entry();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand_char();
        int s;
        s = $urandom_range(0, 9);
        if (s < 6) return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        if (s < 8) return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [7:0] idx,
                              input logic [7:0] val, input logic [255:0] ent);
        pend_t pd;
        pd.drain_first     = drain_next;
        pd.item.op         = op;
        pd.item.char_index = idx;
        pd.item.char_value = val;
        pd.item.w0         = ent[63:0];
        pd.item.w1         = ent[127:64];
        pd.item.w2         = ent[191:128];
        pd.item.w3         = ent[255:192];
        pd.item.sector     = ($urandom_range(0, 31) == 0) ? 32'hFFFF_FFFF : $urandom;
        drain_next = 1'b0;
        pending.push_back(pd);
        if (op != OP_UNUSED) phase_items++;
    endtask

    task automatic queue_entry(input logic [255:0] ent);
        queue_item(OP_ENTRY, 8'($urandom), 8'($urandom), ent);
    endtask

    function automatic logic [255:0] short_entry(input int how);
        logic [255:0] ent;
        ent = rand_entry();
        if (ent[95:88] == ATTR_LFN) ent[95:88] = 8'h20;
        if (how == SN_RANDOM) begin
            if (ent[7:0] == DIR_END || ent[7:0] == DIR_DELETED) ent[7:0] = 8'h41;
        end else begin
            ent[63:0]  = phase_base;
            ent[87:64] = phase_ext;
            if (how == SN_NEAR)
                ent[8*$urandom_range(0, 10) +: 8] ^= 8'(1 << $urandom_range(0, 7));
        end
        return ent;
    endfunction

    function automatic logic [255:0] long_entry(input int n, input bit first);
        logic [255:0] ent;
        logic [15:0]  unit;
        int           k;
        int           p;
        ent = rand_entry();
        ent[7:0]   = 8'(n) | (first ? SEQ_LAST_MASK : 8'h00);
        ent[95:88] = ATTR_LFN;
        for (k = 0; k < LFN_CHARS; k++) begin
            p = (n - 1) * LFN_CHARS + k;
            if (p < lname_len) begin
                unit = {8'h00, lname[p]};
                if ($urandom_range(0, 7) == 0) unit[15:8] = 8'($urandom_range(1, 254));
            end else if (p == lname_len) begin
                unit = $urandom_range(0, 1) ? UNIT_NONE : UNIT_PAD;
            end else begin
                unit = UNIT_PAD;
            end
            ent[8*unit_byte(k) +: 16] = unit;
        end
        return ent;
    endfunction

    // build lname from the target, case-flipped, optionally off by one char
    task automatic make_lfn(input bit exact);
        int eff;
        int j;
        eff = 0;
        while (eff < want_len && want_name[eff] != 8'h00) eff++;
        if (eff == 0) begin
            lname_len = $urandom_range(1, 30);
            for (j = 0; j < lname_len; j++) lname[j] = rand_char();
        end else begin
            lname_len = eff;
            for (j = 0; j < eff; j++) begin
                lname[j] = want_name[j];
                if (upcase(lname[j]) >= 8'h41 && upcase(lname[j]) <= 8'h5A &&
                    $urandom_range(0, 1) == 1)
                    lname[j] = lname[j] ^ 8'h20;
            end
            if (!exact) begin
                case ($urandom_range(0, 2))
                    0: begin
                        j = $urandom_range(0, eff - 1);
                        lname[j] = (lname[j] == 8'hFF) ? 8'h41 : upcase(lname[j]) + 8'h01;
                    end
                    1: begin
                        lname[lname_len] = rand_char();
                        lname_len++;
                    end
                    default: lname_len--;
                endcase
            end
        end
    endtask

    task automatic queue_long_name(input int brk, input int sn);
        logic [255:0] ent;
        int           cnt;
        int           skip;
        int           n;
        cnt  = (lname_len + LFN_CHARS - 1) / LFN_CHARS;
        skip = (cnt > 0) ? $urandom_range(1, cnt) : 0;
        for (n = cnt; n >= 1; n--) begin
            ent = long_entry(n, n == cnt);
            if (brk == BRK_NOLAST && n == cnt) ent[6] = 1'b0;
            if (brk == BRK_BADSEQ && n == cnt) ent[5:0] = 6'($urandom_range(0, 63));
            if (!(brk == BRK_SKIP && n == skip)) queue_entry(ent);
            if (brk == BRK_INSERT && n == skip) begin
                if ($urandom_range(0, 1)) begin
                    queue_item(OP_START, 8'($urandom), 8'($urandom), rand_entry());
                end else begin
                    ent = rand_entry();
                    ent[7:0] = DIR_DELETED;
                    queue_entry(ent);
                end
            end
        end
        queue_entry(short_entry(sn));
    endtask

    function automatic int pick_short();
        int s;
        s = $urandom_range(0, 99);
        if (s < 25) return SN_MATCH;
        if (s < 40) return SN_NEAR;
        return SN_RANDOM;
    endfunction

    task automatic queue_noise();
        logic [255:0] ent;
        ent = rand_entry();
        case ($urandom_range(0, 9))
            0: queue_item(OP_START, 8'($urandom), 8'($urandom), ent);
            1: queue_item(OP_UNUSED, 8'($urandom), 8'($urandom), ent);
            // keep the target intact: load only above its length
            2: queue_item(OP_LOAD, 8'($urandom_range(want_len, MAX_NAME - 1)),
                          8'($urandom), ent);
            3: begin
                ent[7:0] = DIR_END;
                queue_entry(ent);
            end
            4: begin
                ent[7:0] = DIR_DELETED;
                queue_entry(ent);
            end
            5, 6: begin
                ent[95:88] = ATTR_LFN;
                if (ent[7:0] == DIR_END || ent[7:0] == DIR_DELETED) ent[7:0] = 8'h41;
                queue_entry(ent);
            end
            default: queue_entry(ent);
        endcase
    endtask

    initial begin : stim
        logic [255:0] ent;
        logic [63:0]  ext_word;
        int           ph;
        int           j;
        int           sel;
        bit           drained;
        lfn_len     = '0;
        seq_next    = '0;
        tgt_base    = BASE_RESET;
        tgt_ext     = EXT_RESET;
        tgt_len     = '0;
        phase_base  = BASE_RESET;
        phase_ext   = EXT_RESET;
        want_len    = 0;
        errors      = 0;
        cycles      = 0;
        steady      = 1'b0;
        drain_next  = 1'b0;
        offering    = 1'b0;
        phase_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ignored kind, end marker, deleted, reset 8.3 match, miss, start
        queue_item(OP_UNUSED, 8'hFF, 8'hFF, '1);
        ent = '1;
        ent[7:0] = DIR_END;
        queue_entry(ent);
        ent = '0;
        ent[7:0] = DIR_DELETED;
        queue_entry(ent);
        ent = '1;
        ent[63:0]  = BASE_RESET;
        ent[87:64] = EXT_RESET;
        queue_entry(ent);
        ent = '0;
        ent[7:0] = 8'h41;
        queue_entry(ent);
        queue_item(OP_START, 8'h00, 8'h00, '0);

        // fill the whole target store so no unwritten character is ever read
        for (j = 0; j < MAX_NAME; j++)
            queue_item(OP_LOAD, 8'(j), (j == 0) ? 8'hFF : (j == 1) ? 8'h00 : 8'($urandom),
                       rand_entry());

        // write every long-name match bit once with a full 20-entry name
        lname_len = MAX_LFN;
        for (j = 0; j < lname_len; j++) lname[j] = rand_char();
        queue_long_name(BRK_NONE, SN_RANDOM);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            steady     = (ph == 1);
            phase_base = {$urandom, $urandom};
            phase_ext  = 24'($urandom);
            if (phase_base[7:0] == DIR_END || phase_base[7:0] == DIR_DELETED)
                phase_base[7:0] = 8'h46;
            case (ph)
                0: want_len = 8;
                1: want_len = 13;
                2: want_len = 255;
                3: begin
                    want_len   = 1;
                    phase_base = '1;
                    phase_ext  = '1;
                end
                4: want_len = 26;
                5: want_len = $urandom_range(2, 60);
                default: begin
                    want_len   = 0;
                    phase_base = '0;
                    phase_ext  = '0;
                end
            endcase
            for (j = 0; j < want_len; j++) want_name[j] = rand_char();
            // a zero inside the target ends the name early
            if (ph == 4) want_name[10] = 8'h00;
            for (j = 0; j < want_len; j++)
                queue_item(OP_LOAD, 8'(j), want_name[j], rand_entry());
            wait_idle();

            ext_word = {$urandom, $urandom};
            ext_word[23:0] = phase_ext;
            if (ph == 3) ext_word = '1;
            apb_write(REG_BASE, phase_base);
            apb_write(REG_EXT, ext_word);
            apb_write(REG_NAME_LEN, {$urandom, 24'($urandom), 8'(want_len)});
            if (ph == 0) apb_write(REG_UNUSED, {$urandom, $urandom});

            phase_items = 0;
            drained = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                if (phase_items >= PHASE_ITEMS / 2 && !drained) begin
                    drain_next = 1'b1;
                    drained = 1'b1;
                end
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    make_lfn($urandom_range(0, 99) < 60);
                    queue_long_name(BRK_NONE, pick_short());
                end else if (sel < 62) begin
                    queue_entry(short_entry(($urandom_range(0, 1) == 1) ? SN_MATCH : SN_NEAR));
                end else if (sel < 74) begin
                    make_lfn(1'b1);
                    queue_long_name($urandom_range(BRK_SKIP, BRK_BADSEQ), pick_short());
                end else begin
                    queue_noise();
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("fat_dir_entry_lookup verification clean");
        end else begin
            $display("fat_dir_entry_lookup verification failed");
        end
        $finish;
    end

endmodule

// File: fat_dir_entry_lookup.f
+incdir+sv
sv/fdel_pkg.sv
sv/fdel_cfg_regs.sv
sv/fdel_name_store.sv
sv/fdel_scan_core.sv
sv/fat_dir_entry_lookup.sv
tb/testbench.sv
